>>> rtl/bbat_pkg.sv
package bbat_pkg;

  // Fraction bits of a coefficient; products are shifted down by this much.
  localparam int COEF_FRAC = 12;

  // Configuration port address width: registers sit at byte address 8*i.
  localparam int ADDR_W = 6;

  localparam logic [2:0] REG_LIN_X   = 3'd0;
  localparam logic [2:0] REG_LIN_Y   = 3'd1;
  localparam logic [2:0] REG_LIN_Z   = 3'd2;
  localparam logic [2:0] REG_SHIFT_X = 3'd3;
  localparam logic [2:0] REG_SHIFT_Y = 3'd4;
  localparam logic [2:0] REG_SHIFT_Z = 3'd5;

  localparam logic [1:0] LAST_AXIS   = 2'd2;
  localparam logic [2:0] LAST_CORNER = 3'd7;

  // Bit k of entry a is set when corner k takes axis a from the high side.
  localparam logic [2:0][7:0] HIGH_SIDE = '{8'b0011_0011, 8'b0000_1111, 8'b1001_1001};

  typedef enum logic [2:0] {
    ACT_CLEAR = 3'd0,
    ACT_BEGIN = 3'd1,
    ACT_ADD   = 3'd2,
    ACT_AABB  = 3'd3,
    ACT_OBB   = 3'd4
  } act_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DRAIN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic       box_clear;
    logic       box_begin;
    logic       box_add;
    logic       q_start;
    logic       q_aabb;
    logic       mul_en;
    logic [1:0] row;
    logic [1:0] col;
    logic       load;
    logic [2:0] k;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } stat_t;

endpackage

>>> rtl/bbat_regs.sv
module bbat_regs
  import bbat_pkg::*;
#(
  parameter int COORD_W = 32,
  parameter int COEF_W  = 16,
  parameter int DATA_W  = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [ADDR_W-1:0]               paddr,
  input  logic [DATA_W-1:0]               pwdata,
  output logic [DATA_W-1:0]               prdata,
  output logic                            pready,
  output logic [2:0][3*COEF_W-1:0]        lin_row,
  output logic [2:0][COORD_W-1:0]         shift
);

  logic [2:0] idx;
  logic       wr;

  assign idx    = paddr[ADDR_W-1:3];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        lin_row[i] <= (3*COEF_W)'(1) << (COEF_FRAC + i*COEF_W);
        shift[i]   <= '0;
      end
    end else if (wr) begin
      unique case (idx)
        REG_LIN_X:   lin_row[0] <= pwdata[3*COEF_W-1:0];
        REG_LIN_Y:   lin_row[1] <= pwdata[3*COEF_W-1:0];
        REG_LIN_Z:   lin_row[2] <= pwdata[3*COEF_W-1:0];
        REG_SHIFT_X: shift[0]   <= pwdata[COORD_W-1:0];
        REG_SHIFT_Y: shift[1]   <= pwdata[COORD_W-1:0];
        REG_SHIFT_Z: shift[2]   <= pwdata[COORD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_LIN_X:   prdata = DATA_W'(lin_row[0]);
      REG_LIN_Y:   prdata = DATA_W'(lin_row[1]);
      REG_LIN_Z:   prdata = DATA_W'(lin_row[2]);
      REG_SHIFT_X: prdata = DATA_W'(shift[0]);
      REG_SHIFT_Y: prdata = DATA_W'(shift[1]);
      REG_SHIFT_Z: prdata = DATA_W'(shift[2]);
      default:     prdata = '0;
    endcase
  end

endmodule

>>> rtl/bbat_ctrl.sv
module bbat_ctrl
  import bbat_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [2:0] action,
  output logic       in_ready,
  input  stat_t      stat,
  output cmd_t       cmd
);

  state_t     state, state_next;
  logic [1:0] row, col;
  logic [2:0] k;
  logic       accept;
  act_t       act;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign act      = act_t'(action);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && (act == ACT_AABB || act == ACT_OBB)) state_next = ST_MUL;
      end
      ST_MUL: begin
        if (row == LAST_AXIS && col == LAST_AXIS) state_next = ST_DRAIN;
      end
      ST_DRAIN: state_next = ST_EMIT;
      ST_EMIT: begin
        if (stat.out_free && k == LAST_CORNER) state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd     = '0;
    cmd.row = row;
    cmd.col = col;
    cmd.k   = k;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (act)
            ACT_CLEAR: cmd.box_clear = 1'b1;
            ACT_BEGIN: cmd.box_begin = 1'b1;
            ACT_ADD:   cmd.box_add   = 1'b1;
            ACT_AABB: begin
              cmd.q_start = 1'b1;
              cmd.q_aabb  = 1'b1;
            end
            ACT_OBB:   cmd.q_start   = 1'b1;
            default: ;
          endcase
        end
      end
      ST_MUL:   cmd.mul_en = 1'b1;
      ST_DRAIN: ;
      ST_EMIT:  cmd.load   = stat.out_free;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      row   <= '0;
      col   <= '0;
      k     <= '0;
    end else begin
      state <= state_next;
      if (cmd.mul_en) begin
        if (col == LAST_AXIS) begin
          col <= '0;
          row <= (row == LAST_AXIS) ? 2'd0 : row + 2'd1;
        end else begin
          col <= col + 2'd1;
        end
      end
      // The corner counter wraps to zero after the eighth word.
      if (cmd.load) k <= k + 3'd1;
    end
  end

  a_start_clean: assert property (@(posedge clk) disable iff (rst)
    cmd.q_start |=> (state == ST_MUL && row == 2'd0 && col == 2'd0))
    else $error("query did not start at the first coefficient");

  a_emit_end: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT && cmd.load && k == LAST_CORNER) |=> (state == ST_IDLE && k == 3'd0))
    else $error("query did not end after the eighth corner");

endmodule

>>> rtl/bbat_dp.sv
module bbat_dp
  import bbat_pkg::*;
#(
  parameter int COORD_W = 32,
  parameter int COEF_W  = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  cmd_t                      cmd,
  output stat_t                     stat,
  input  logic [2:0][3*COEF_W-1:0]  lin_row,
  input  logic [2:0][COORD_W-1:0]   shift,
  input  logic signed [COORD_W-1:0] pos_x,
  input  logic signed [COORD_W-1:0] pos_y,
  input  logic signed [COORD_W-1:0] pos_z,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [2:0]                corner_index,
  output logic signed [COORD_W-1:0] corner_x,
  output logic signed [COORD_W-1:0] corner_y,
  output logic signed [COORD_W-1:0] corner_z,
  output logic                      last_corner,
  output logic                      box_valid
);

  localparam int PROD_W = COORD_W + COEF_W;
  localparam int TERM_W = PROD_W - COEF_FRAC;
  localparam int SUM_W  = ((TERM_W > COORD_W) ? TERM_W : COORD_W) + 2;

  localparam logic signed [SUM_W-1:0] SAT_MAX =
    {{(SUM_W-COORD_W+1){1'b0}}, {(COORD_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SAT_MIN = ~SAT_MAX;

  localparam logic signed [COORD_W-1:0] BEGIN_LOW  = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] BEGIN_HIGH = {1'b1, {(COORD_W-2){1'b0}}, 1'b1};

  logic signed [COORD_W-1:0] low  [3];
  logic signed [COORD_W-1:0] high [3];
  logic signed [COORD_W-1:0] pos  [3];
  logic                      flag;
  logic                      mode_aabb;

  logic signed [COEF_W-1:0]  coef;
  logic signed [PROD_W-1:0]  prod_a, prod_b;
  logic                      pend;
  logic [1:0]                pend_row, pend_col;
  logic signed [TERM_W-1:0]  term_a, term_b;
  logic signed [TERM_W-1:0]  lo_term [3][3];
  logic signed [TERM_W-1:0]  hi_term [3][3];

  logic signed [SUM_W-1:0]   sum [3];
  logic [2:0][COORD_W-1:0]   sat;

  assign pos[0] = pos_x;
  assign pos[1] = pos_y;
  assign pos[2] = pos_z;

  assign stat.out_free = !out_valid || out_ready;

  // Box state: clear, begin and add vertex each write the box registers as they are taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        low[i]  <= '0;
        high[i] <= '0;
      end
      flag <= 1'b0;
    end else if (cmd.box_clear) begin
      for (int i = 0; i < 3; i++) begin
        low[i]  <= '0;
        high[i] <= '0;
      end
      flag <= 1'b0;
    end else if (cmd.box_begin) begin
      for (int i = 0; i < 3; i++) begin
        low[i]  <= BEGIN_LOW;
        high[i] <= BEGIN_HIGH;
      end
      flag <= 1'b1;
    end else if (cmd.box_add) begin
      for (int i = 0; i < 3; i++) begin
        if (pos[i] < low[i])  low[i]  <= pos[i];
        if (pos[i] > high[i]) high[i] <= pos[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.q_start) mode_aabb <= cmd.q_aabb;
  end

  // One coefficient per cycle, multiplied by the low and the high coordinate
  // of its input axis on two multipliers.
  assign coef = $signed(lin_row[cmd.row][cmd.col*COEF_W +: COEF_W]);

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod_a   <= coef * low[cmd.col];
      prod_b   <= coef * high[cmd.col];
      pend_row <= cmd.row;
      pend_col <= cmd.col;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) pend <= 1'b0;
    else     pend <= cmd.mul_en;
  end

  always_comb begin
    term_a = TERM_W'(prod_a >>> COEF_FRAC);
    term_b = TERM_W'(prod_b >>> COEF_FRAC);
  end

  // For the AABB query the terms are ordered here, so that the corner sums
  // only have to pick a side per term.
  always_ff @(posedge clk) begin
    if (pend) begin
      if (mode_aabb && term_b < term_a) begin
        lo_term[pend_row][pend_col] <= term_b;
        hi_term[pend_row][pend_col] <= term_a;
      end else begin
        lo_term[pend_row][pend_col] <= term_a;
        hi_term[pend_row][pend_col] <= term_b;
      end
    end
  end

  always_comb begin
    logic sel;
    for (int i = 0; i < 3; i++) begin
      sum[i] = SUM_W'($signed(shift[i]));
      for (int j = 0; j < 3; j++) begin
        sel    = mode_aabb ? HIGH_SIDE[i][cmd.k] : HIGH_SIDE[j][cmd.k];
        sum[i] = sum[i] + (sel ? SUM_W'(hi_term[i][j]) : SUM_W'(lo_term[i][j]));
      end
      if (sum[i] > SAT_MAX)      sat[i] = SAT_MAX[COORD_W-1:0];
      else if (sum[i] < SAT_MIN) sat[i] = SAT_MIN[COORD_W-1:0];
      else                       sat[i] = sum[i][COORD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      corner_index <= cmd.k;
      corner_x     <= sat[0];
      corner_y     <= sat[1];
      corner_z     <= sat[2];
      last_corner  <= (cmd.k == LAST_CORNER);
      box_valid    <= flag;
    end
  end

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> stat.out_free)
    else $error("corner word loaded over one not yet taken");

  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last_corner == (corner_index == LAST_CORNER)))
    else $error("last corner flag disagrees with corner index");

  a_store_follows: assert property (@(posedge clk) disable iff (rst)
    cmd.mul_en |=> pend)
    else $error("product not stored after multiply");

endmodule

>>> rtl/bounding_box_accumulate_transform.sv
// Bounding box accumulator with transformed corner queries. Clear, begin and
// add vertex words are taken one per cycle while no query is in progress and
// finish in that cycle. After a query word (AABB or transformed box) no
// further input word is taken until the query is done: the controller steps
// through the 3x3 coefficients on two shared multipliers (one for the low,
// one for the high corner), a drain step stores the last products, and then
// eight corner words are produced one at a time into the output register;
// output stalls hold this last step until the output side takes each word.
// Coordinates are Q16.16 and coefficients Q4.12; each product is floored back
// to Q16.16, and only the final sum with the translation is saturated. The
// configuration registers sit at byte addresses 8*i, 64-bit data.
module bounding_box_accumulate_transform
  import bbat_pkg::*;
#(
  parameter int COORD_WIDTH = 32,
  parameter int COEF_WIDTH  = 16,
  localparam int REG_MAX_W  = (3*COEF_WIDTH > COORD_WIDTH) ? 3*COEF_WIDTH : COORD_WIDTH,
  localparam int DATA_W     = 64 * ((REG_MAX_W + 63) / 64)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ADDR_W-1:0]             paddr,
  input  logic [DATA_W-1:0]             pwdata,
  output logic [DATA_W-1:0]             prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [2:0]                    action,
  input  logic signed [COORD_WIDTH-1:0] pos_x,
  input  logic signed [COORD_WIDTH-1:0] pos_y,
  input  logic signed [COORD_WIDTH-1:0] pos_z,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [2:0]                    corner_index,
  output logic signed [COORD_WIDTH-1:0] corner_x,
  output logic signed [COORD_WIDTH-1:0] corner_y,
  output logic signed [COORD_WIDTH-1:0] corner_z,
  output logic                          last_corner,
  output logic                          box_valid
);

  logic [2:0][3*COEF_WIDTH-1:0] lin_row;
  logic [2:0][COORD_WIDTH-1:0]  shift;
  cmd_t                         cmd;
  stat_t                        stat;

  bbat_regs #(
    .COORD_W (COORD_WIDTH),
    .COEF_W  (COEF_WIDTH),
    .DATA_W  (DATA_W)
  ) u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .lin_row (lin_row),
    .shift   (shift)
  );

  bbat_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .action   (action),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  bbat_dp #(
    .COORD_W (COORD_WIDTH),
    .COEF_W  (COEF_WIDTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .lin_row      (lin_row),
    .shift        (shift),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .pos_z        (pos_z),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .corner_index (corner_index),
    .corner_x     (corner_x),
    .corner_y     (corner_y),
    .corner_z     (corner_z),
    .last_corner  (last_corner),
    .box_valid    (box_valid)
  );

endmodule
